// ===== hdl/gphm_pkg.sv =====
// ----------------------------------------------------------------------------
// Ground plane homography mapper package
// Register indexes, field widths and result limits shared by the mapper.
// ----------------------------------------------------------------------------
package gphm_pkg;

  localparam int COEF_W  = 40;
  localparam int OUT_W   = 20;
  localparam int IDX_W   = 3;
  localparam int Q_BITS  = 20;
  localparam int ONE_Q16 = 65536;

  typedef enum logic [IDX_W-1:0] {
    REG_A = 3'd0,
    REG_B = 3'd1,
    REG_C = 3'd2,
    REG_D = 3'd3,
    REG_E = 3'd4,
    REG_F = 3'd5,
    REG_G = 3'd6,
    REG_H = 3'd7
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [OUT_W-1:0]  coord_out_t;

  localparam logic [OUT_W-1:0] OUT_MAX_MAG = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN_MAG = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

// ===== hdl/ground_plane_homography_mapper.sv =====
// ----------------------------------------------------------------------------
// Ground plane homography mapper
// Maps a pixel through a 3x3 projective transform with perspective divide.
// ----------------------------------------------------------------------------
// Usage: software writes the eight Q23.16 coefficients on the cfg channel
// (index 0 to 7 selects a through h) while no request is in flight. Each
// request on the in channel carries one pixel (in_x, in_y); each response on
// the out channel carries the mapped position in sixteenths of a pixel, the
// behind-horizon flag and the clipped flag. One request is taken every clock
// cycle unless the receiver stalls. Pipeline stages: multiply, sum, operand
// setup, one overflow check stage, one stage per quotient bit of the two
// parallel restoring dividers, and the saturating output register. The
// divider depth sets the latency. When the receiver stalls, the whole
// pipeline holds and in_ready drops; nothing is lost or repeated. Reset
// empties the pipeline and loads the identity transform.
// ----------------------------------------------------------------------------
module ground_plane_homography_mapper #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gphm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [gphm_pkg::COEF_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [COORD_BITS-1:0]         in_x,
  input  logic [COORD_BITS-1:0]         in_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [gphm_pkg::OUT_W-1:0] out_u,
  output logic signed [gphm_pkg::OUT_W-1:0] out_v,
  output logic                          out_behind_horizon,
  output logic                          out_clipped
);
  import gphm_pkg::*;

  localparam int PW = COEF_W + COORD_BITS + 1;
  localparam int SW = PW + 2;
  localparam int NW = SW + 6;
  localparam int DW = SW + 1;
  localparam int RW = SW + Q_BITS + 2;
  localparam int QS = Q_BITS + 1;

  coef_t coef_r [0:7];
  logic  en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) coef_r[i] <= '0;
      coef_r[REG_A] <= coef_t'(ONE_Q16);
      coef_r[REG_E] <= coef_t'(ONE_Q16);
    end else if (cfg_valid) begin
      coef_r[cfg_index] <= coef_t'(cfg_data);
    end
  end

  // Stage A: products.
  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PW-1:0] pa_r, pb_r, pd_r, pe_r, pg_r, ph_r;
  logic va_r;

  assign xs = $signed({1'b0, in_x});
  assign ys = $signed({1'b0, in_y});

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= PW'(coef_r[REG_A] * xs);
      pb_r <= PW'(coef_r[REG_B] * ys);
      pd_r <= PW'(coef_r[REG_D] * xs);
      pe_r <= PW'(coef_r[REG_E] * ys);
      pg_r <= PW'(coef_r[REG_G] * xs);
      ph_r <= PW'(coef_r[REG_H] * ys);
    end
  end

  // Stage B: sums.
  logic signed [SW-1:0] nu_r, nv_r, den_r;
  logic vb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nu_r  <= SW'(pa_r) + SW'(pb_r) + SW'(coef_r[REG_C]);
      nv_r  <= SW'(pd_r) + SW'(pe_r) + SW'(coef_r[REG_F]);
      den_r <= SW'(pg_r) + SW'(ph_r) + SW'(ONE_Q16);
    end
  end

  // Stage C: divider operands, N = 32*|num| + den and D = 2*den.
  logic [SW-1:0] magu, magv;
  logic          behind_c;

  assign magu     = nu_r[SW-1] ? SW'(-nu_r) : SW'(nu_r);
  assign magv     = nv_r[SW-1] ? SW'(-nv_r) : SW'(nv_r);
  assign behind_c = den_r[SW-1] || (den_r == '0);

  logic [RW-1:0]     ru_r  [0:QS];
  logic [RW-1:0]     rv_r  [0:QS];
  logic [DW-1:0]     dd_r  [0:QS];
  logic [Q_BITS-1:0] qu_r  [0:QS];
  logic [Q_BITS-1:0] qv_r  [0:QS];
  logic              ovu_r [0:QS];
  logic              ovv_r [0:QS];
  logic              ngu_r [0:QS];
  logic              ngv_r [0:QS];
  logic              bh_r  [0:QS];
  logic              vd_r  [0:QS];

  always_ff @(posedge clk) begin
    if (en) begin
      ru_r[0]  <= RW'(NW'({magu, 5'b0}) + NW'(den_r));
      rv_r[0]  <= RW'(NW'({magv, 5'b0}) + NW'(den_r));
      dd_r[0]  <= DW'({den_r, 1'b0});
      qu_r[0]  <= '0;
      qv_r[0]  <= '0;
      ovu_r[0] <= 1'b0;
      ovv_r[0] <= 1'b0;
      ngu_r[0] <= nu_r[SW-1];
      ngv_r[0] <= nv_r[SW-1];
      bh_r[0]  <= behind_c;
    end
  end

  // Restoring divider: stage j tests quotient bit Q_BITS-j; the top bit
  // only marks overflow.
  for (genvar j = 0; j < QS; j++) begin : g_div
    localparam int SH = Q_BITS - j;
    logic [RW-1:0] dsh;
    logic          geu, gev;

    assign dsh = RW'(dd_r[j]) << SH;
    assign geu = ru_r[j] >= dsh;
    assign gev = rv_r[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        ru_r[j+1]  <= geu ? ru_r[j] - dsh : ru_r[j];
        rv_r[j+1]  <= gev ? rv_r[j] - dsh : rv_r[j];
        dd_r[j+1]  <= dd_r[j];
        ngu_r[j+1] <= ngu_r[j];
        ngv_r[j+1] <= ngv_r[j];
        bh_r[j+1]  <= bh_r[j];
        if (SH == Q_BITS) begin
          qu_r[j+1]  <= qu_r[j];
          qv_r[j+1]  <= qv_r[j];
          ovu_r[j+1] <= geu;
          ovv_r[j+1] <= gev;
        end else begin
          qu_r[j+1]  <= qu_r[j] | (Q_BITS'(geu) << SH);
          qv_r[j+1]  <= qv_r[j] | (Q_BITS'(gev) << SH);
          ovu_r[j+1] <= ovu_r[j];
          ovv_r[j+1] <= ovv_r[j];
        end
      end
    end
  end

  // Output stage: sign, saturation and horizon handling.
  logic [OUT_W-1:0] u_nxt, v_nxt;
  logic             satu, satv, clip_nxt;
  logic [OUT_W-1:0] u_r, v_r;
  logic             behind_r, clip_r, vo_r;

  always_comb begin
    satu = ovu_r[QS] || (ngu_r[QS] ? (qu_r[QS] > OUT_MIN_MAG) : (qu_r[QS] > OUT_MAX_MAG));
    satv = ovv_r[QS] || (ngv_r[QS] ? (qv_r[QS] > OUT_MIN_MAG) : (qv_r[QS] > OUT_MAX_MAG));
    if (ngu_r[QS]) begin
      u_nxt = satu ? OUT_MIN_MAG : OUT_W'(-qu_r[QS]);
    end else begin
      u_nxt = satu ? OUT_MAX_MAG : qu_r[QS];
    end
    if (ngv_r[QS]) begin
      v_nxt = satv ? OUT_MIN_MAG : OUT_W'(-qv_r[QS]);
    end else begin
      v_nxt = satv ? OUT_MAX_MAG : qv_r[QS];
    end
    clip_nxt = satu || satv;
    if (bh_r[QS]) begin
      u_nxt    = '0;
      v_nxt    = '0;
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      behind_r <= bh_r[QS];
      clip_r   <= clip_nxt;
    end
  end

  // Valid bits travel with the data; the whole pipe holds on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= QS; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      vb_r    <= va_r;
      vd_r[0] <= vb_r;
      for (int k = 0; k < QS; k++) vd_r[k+1] <= vd_r[k];
      vo_r    <= vd_r[QS];
    end
  end

  assign en       = !vo_r || out_ready;
  assign in_ready = en;

  assign out_valid          = vo_r;
  assign out_u              = $signed(u_r);
  assign out_v              = $signed(v_r);
  assign out_behind_horizon = behind_r;
  assign out_clipped        = clip_r;

endmodule
